// ===== rtl/core/obj_text_record_number_parser_macros.svh =====
// Assertion macros shared by the OBJ text record number parser RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef OBJ_TEXT_RECORD_NUMBER_PARSER_MACROS_SVH
`define OBJ_TEXT_RECORD_NUMBER_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OTRNP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OTRNP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/otrnp_pkg.sv =====
// Package for the OBJ text record number parser: character codes, record
// kinds, state enums, control/status structs and small constant tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package otrnp_pkg;

   // Character codes
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_POINT   = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_V       = 8'h76;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NUL     = 8'h00;

   // Record kinds
   localparam logic [1:0] KIND_VERTEX  = 2'd0;
   localparam logic [1:0] KIND_TEXTURE = 2'd1;
   localparam logic [1:0] KIND_NORMAL  = 2'd2;
   localparam logic [1:0] KIND_FACE    = 2'd3;

   localparam int FIELD_W = 4;

   // Line parser phase
   typedef enum logic [2:0] {
      PH_START,
      PH_AFTER_V,
      PH_HEADER,
      PH_FIELDS,
      PH_SKIP
   } line_phase_type;

   // Sequencer for the field-end division
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DIVIDE,
      SEQ_PACK
   } seq_state_type;

   // Datapath to controller
   typedef struct packed {
      logic is_eol;
      logic is_space;
      logic is_f;
      logic is_v;
      logic is_t;
      logic is_n;
      logic is_minus;
      logic is_point;
      logic is_digit;
      logic field_start;
      logic record_full;
      logic rsp_free;
   } otrnp_status_type;

   // Controller to datapath
   typedef struct packed {
      logic       set_kind;
      logic [1:0] kind;
      logic       start_fields;
      logic       clear_field;
      logic       take_minus;
      logic       take_point;
      logic       take_digit;
      logic       emit;
      logic       bump_field;
      logic       div_step;
      logic       pack;
   } otrnp_cmd_type;

   // Number of fields per record kind
   function automatic logic [FIELD_W-1:0] field_total(input logic [1:0] kind);
      logic [FIELD_W-1:0] n;
      unique case (kind)
         KIND_VERTEX:  n = FIELD_W'(3);
         KIND_TEXTURE: n = FIELD_W'(2);
         KIND_NORMAL:  n = FIELD_W'(3);
         KIND_FACE:    n = FIELD_W'(9);
         default:      n = FIELD_W'(3);
      endcase
      return n;
   endfunction

   // Powers of ten for the fraction scaling
   function automatic logic [63:0] pow10(input int unsigned n);
      logic [63:0] p;
      unique case (n)
         0:       p = 64'd1;
         1:       p = 64'd10;
         2:       p = 64'd100;
         3:       p = 64'd1000;
         4:       p = 64'd10000;
         5:       p = 64'd100000;
         6:       p = 64'd1000000;
         7:       p = 64'd10000000;
         8:       p = 64'd100000000;
         9:       p = 64'd1000000000;
         10:      p = 64'd10000000000;
         11:      p = 64'd100000000000;
         12:      p = 64'd1000000000000;
         default: p = 64'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/otrnp_datapath.sv =====
// Datapath of the OBJ text record number parser: byte decode, field
// accumulator, bit-serial restoring divider and result register.
// Depends on otrnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otrnp_datapath #(
   parameter int MANTISSA_BITS   = 32,
   parameter int MAX_FRAC_DIGITS = 9,
   parameter int FRAC_BITS       = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [7:0]                text_byte,
   input  otrnp_pkg::otrnp_cmd_type  cmd,
   output otrnp_pkg::otrnp_status_type status,
   input  wire                       rsp_stall,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_record_kind,
   output logic [3:0]                rsp_field_number,
   output logic signed [31:0]        rsp_fixed_value,
   output logic signed [31:0]        rsp_index_value,
   output logic                      rsp_overflow,
   output logic                      rsp_last_of_record
);
   import otrnp_pkg::*;

   localparam int MB    = MANTISSA_BITS;
   localparam int FD_W  = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int DW    = MANTISSA_BITS + FRAC_BITS;
   localparam int DIV_W = $clog2(pow10(MAX_FRAC_DIGITS) + 64'd1);
   localparam int CW    = (DW > 33) ? DW : 33;

   localparam logic [MB-1:0] M_MAX = {MB{1'b1}};
   localparam logic [CW-1:0] LIM_POS = CW'(32'h7FFF_FFFF);
   localparam logic [CW-1:0] LIM_NEG = CW'(32'h8000_0000);

   // Field accumulator state
   logic [1:0]         kind_ff, kind_in;
   logic [FIELD_W-1:0] fc_ff, fc_in;
   logic [MB-1:0]      m_ff, m_in;
   logic [FD_W-1:0]    fd_ff, fd_in;
   logic               neg_ff, neg_in;
   logic               point_ff, point_in;
   logic               start_ff, start_in;
   logic               sat_ff, sat_in;

   // Divider and snapshot of the field being scaled
   logic [DW-1:0]      dq_ff, dq_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic [1:0]         s_kind_ff, s_kind_in;
   logic [FIELD_W-1:0] s_fc_ff, s_fc_in;
   logic               s_neg_ff, s_neg_in;
   logic               s_sat_ff, s_sat_in;
   logic               s_last_ff, s_last_in;

   // Result register
   logic               rv_ff, rv_in;
   logic [1:0]         r_kind_ff, r_kind_in;
   logic [3:0]         r_fc_ff, r_fc_in;
   logic [31:0]        r_fixed_ff, r_fixed_in;
   logic [31:0]        r_index_ff, r_index_in;
   logic               r_ovf_ff, r_ovf_in;
   logic               r_last_ff, r_last_in;

   logic [MB+3:0]      digit_sum;
   logic               digit_ok;
   logic [FIELD_W:0]   fc_plus;
   logic [FIELD_W:0]   total_ext;
   logic [DIV_W:0]     trial;
   logic               qbit;
   logic [CW-1:0]      q_ext;
   logic [CW-1:0]      lim;
   logic               res_ovf;
   logic [31:0]        v;
   logic [31:0]        fixed_val;
   logic [31:0]        index_val;

   // Byte decode and field status
   always_comb begin
      fc_plus   = {1'b0, fc_ff} + (FIELD_W+1)'(1);
      total_ext = {1'b0, field_total(kind_ff)};
      status.is_eol      = (text_byte == CH_NEWLINE) || (text_byte == CH_NUL);
      status.is_space    = (text_byte == CH_SPACE);
      status.is_f        = (text_byte == CH_F);
      status.is_v        = (text_byte == CH_V);
      status.is_t        = (text_byte == CH_T);
      status.is_n        = (text_byte == CH_N);
      status.is_minus    = (text_byte == CH_MINUS);
      status.is_point    = (text_byte == CH_POINT);
      status.is_digit    = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
      status.field_start = start_ff;
      status.record_full = (fc_plus >= total_ext);
      status.rsp_free    = !rv_ff || !rsp_stall;
   end

   // Mantissa step: m*10 + d, saturating
   always_comb begin
      digit_sum = {1'b0, m_ff, 3'b000} + {3'b000, m_ff, 1'b0} +
                  (MB+4)'(text_byte[3:0]);
      digit_ok  = !point_ff || (fd_ff < FD_W'(MAX_FRAC_DIGITS));
   end

   // Field accumulator next state
   always_comb begin
      kind_in  = kind_ff;
      fc_in    = fc_ff;
      m_in     = m_ff;
      fd_in    = fd_ff;
      neg_in   = neg_ff;
      point_in = point_ff;
      start_in = start_ff;
      sat_in   = sat_ff;
      if (cmd.set_kind) begin
         kind_in = cmd.kind;
      end
      if (cmd.bump_field) begin
         fc_in = fc_ff + FIELD_W'(1);
      end
      if (cmd.start_fields || cmd.clear_field) begin
         if (cmd.start_fields) begin
            fc_in = '0;
         end
         m_in     = '0;
         fd_in    = '0;
         neg_in   = 1'b0;
         point_in = 1'b0;
         start_in = 1'b1;
         sat_in   = 1'b0;
      end else if (cmd.take_minus) begin
         neg_in   = 1'b1;
         start_in = 1'b0;
      end else if (cmd.take_point) begin
         point_in = 1'b1;
         start_in = 1'b0;
      end else if (cmd.take_digit) begin
         start_in = 1'b0;
         if (digit_ok) begin
            if (digit_sum > (MB+4)'(M_MAX)) begin
               m_in   = M_MAX;
               sat_in = 1'b1;
            end else begin
               m_in = digit_sum[MB-1:0];
            end
            if (point_ff) begin
               fd_in = fd_ff + FD_W'(1);
            end
         end
      end
   end

   // Restoring division, one quotient bit per step
   always_comb begin
      trial     = {rem_ff, dq_ff[DW-1]};
      qbit      = (trial >= {1'b0, dvs_ff});
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      s_kind_in = s_kind_ff;
      s_fc_in   = s_fc_ff;
      s_neg_in  = s_neg_ff;
      s_sat_in  = s_sat_ff;
      s_last_in = s_last_ff;
      if (cmd.emit) begin
         if (kind_ff == KIND_FACE) begin
            dq_in = DW'(m_ff);
         end else begin
            dq_in = {m_ff, {FRAC_BITS{1'b0}}};
         end
         rem_in    = '0;
         dvs_in    = DIV_W'(pow10(int'(fd_ff)));
         s_kind_in = kind_ff;
         s_fc_in   = fc_ff;
         s_neg_in  = neg_ff;
         s_sat_in  = sat_ff;
         s_last_in = (fc_plus == total_ext);
      end else if (cmd.div_step) begin
         if (qbit) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dq_in = {dq_ff[DW-2:0], qbit};
      end
   end

   // Saturation and sign of the finished quotient
   always_comb begin
      q_ext     = CW'(dq_ff);
      lim       = s_neg_ff ? LIM_NEG : LIM_POS;
      res_ovf   = 1'b0;
      v         = '0;
      fixed_val = '0;
      index_val = '0;
      if (s_kind_ff == KIND_FACE) begin
         if (s_neg_ff) begin
            res_ovf   = (q_ext > LIM_POS);
            index_val = res_ovf ? 32'h8000_0000 : ~q_ext[31:0];
         end else begin
            res_ovf   = (q_ext > LIM_NEG);
            index_val = res_ovf ? 32'h7FFF_FFFF : (q_ext[31:0] - 32'd1);
         end
      end else begin
         res_ovf   = (q_ext > lim);
         v         = res_ovf ? lim[31:0] : q_ext[31:0];
         fixed_val = s_neg_ff ? (32'd0 - v) : v;
      end
   end

   // Result register
   always_comb begin
      rv_in      = rv_ff && rsp_stall;
      r_kind_in  = r_kind_ff;
      r_fc_in    = r_fc_ff;
      r_fixed_in = r_fixed_ff;
      r_index_in = r_index_ff;
      r_ovf_in   = r_ovf_ff;
      r_last_in  = r_last_ff;
      if (cmd.pack) begin
         rv_in      = 1'b1;
         r_kind_in  = s_kind_ff;
         r_fc_in    = s_fc_ff;
         r_fixed_in = fixed_val;
         r_index_in = index_val;
         r_ovf_in   = s_sat_ff || res_ovf;
         r_last_in  = s_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_VERTEX;
         fc_ff    <= '0;
         m_ff     <= '0;
         fd_ff    <= '0;
         neg_ff   <= 1'b0;
         point_ff <= 1'b0;
         start_ff <= 1'b1;
         sat_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         kind_ff  <= kind_in;
         fc_ff    <= fc_in;
         m_ff     <= m_in;
         fd_ff    <= fd_in;
         neg_ff   <= neg_in;
         point_ff <= point_in;
         start_ff <= start_in;
         sat_ff   <= sat_in;
         rv_ff    <= rv_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      s_kind_ff  <= s_kind_in;
      s_fc_ff    <= s_fc_in;
      s_neg_ff   <= s_neg_in;
      s_sat_ff   <= s_sat_in;
      s_last_ff  <= s_last_in;
      r_kind_ff  <= r_kind_in;
      r_fc_ff    <= r_fc_in;
      r_fixed_ff <= r_fixed_in;
      r_index_ff <= r_index_in;
      r_ovf_ff   <= r_ovf_in;
      r_last_ff  <= r_last_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_record_kind    = r_kind_ff;
   assign rsp_field_number   = r_fc_ff;
   assign rsp_fixed_value    = r_fixed_ff;
   assign rsp_index_value    = r_index_ff;
   assign rsp_overflow       = r_ovf_ff;
   assign rsp_last_of_record = r_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/otrnp_ctrl.sv =====
// Controller of the OBJ text record number parser: line classification FSM
// and the sequencer that runs the field-end division and result load.
// Depends on otrnp_pkg and obj_text_record_number_parser_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "obj_text_record_number_parser_macros.svh"

module otrnp_ctrl #(
   parameter int DIV_STEPS = 48
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  otrnp_pkg::otrnp_status_type status,
   output otrnp_pkg::otrnp_cmd_type    cmd
);
   import otrnp_pkg::*;

   localparam int SW = $clog2(DIV_STEPS + 1);

   line_phase_type phase_ff, phase_in;
   seq_state_type  seq_ff, seq_in;
   logic [SW-1:0]  step_ff, step_in;
   logic           accept;

   // Line parser and sequencer
   always_comb begin
      phase_in = phase_ff;
      seq_in   = seq_ff;
      step_in  = step_ff;
      cmd      = '0;
      accept   = req_valid && (seq_ff == SEQ_IDLE);

      if (accept) begin
         unique case (phase_ff)
            PH_START: begin
               if (!status.is_eol) begin
                  if (status.is_f) begin
                     cmd.set_kind = 1'b1;
                     cmd.kind     = KIND_FACE;
                     phase_in     = PH_HEADER;
                  end else if (status.is_v) begin
                     phase_in = PH_AFTER_V;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_AFTER_V: begin
               priority if (status.is_eol) begin
                  phase_in = PH_START;
               end else if (status.is_space) begin
                  cmd.set_kind     = 1'b1;
                  cmd.kind         = KIND_VERTEX;
                  cmd.start_fields = 1'b1;
                  phase_in         = PH_FIELDS;
               end else if (status.is_t) begin
                  cmd.set_kind = 1'b1;
                  cmd.kind     = KIND_TEXTURE;
                  phase_in     = PH_HEADER;
               end else if (status.is_n) begin
                  cmd.set_kind = 1'b1;
                  cmd.kind     = KIND_NORMAL;
                  phase_in     = PH_HEADER;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_HEADER: begin
               if (status.is_eol) begin
                  phase_in = PH_START;
               end else begin
                  cmd.start_fields = 1'b1;
                  phase_in         = PH_FIELDS;
               end
            end
            PH_FIELDS: begin
               priority if (status.field_start && status.is_minus) begin
                  cmd.take_minus = 1'b1;
               end else if (status.is_point) begin
                  cmd.take_point = 1'b1;
               end else if (status.is_digit) begin
                  cmd.take_digit = 1'b1;
               end else begin
                  // separator: emit unless an empty field meets end of line
                  cmd.emit       = !status.field_start || !status.is_eol;
                  cmd.bump_field = 1'b1;
                  if (status.is_eol) begin
                     phase_in = PH_START;
                  end else if (status.record_full) begin
                     phase_in = PH_SKIP;
                  end else begin
                     cmd.clear_field = 1'b1;
                  end
               end
            end
            PH_SKIP: begin
               phase_in = status.is_eol ? PH_START : PH_SKIP;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end

      // Division sequencing
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (cmd.emit) begin
               seq_in  = SEQ_DIVIDE;
               step_in = SW'(DIV_STEPS);
            end
         end
         SEQ_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               seq_in = SEQ_PACK;
            end
         end
         SEQ_PACK: begin
            if (status.rsp_free) begin
               cmd.pack = 1'b1;
               seq_in   = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         seq_ff   <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (seq_ff != SEQ_IDLE);

   // Checks
   `OTRNP_ASSERT_NEXT(a_emit_starts_divide, cmd.emit, seq_ff == SEQ_DIVIDE, "emit did not start division")
   `OTRNP_ASSERT_NOW(a_divide_has_steps, seq_ff == SEQ_DIVIDE, step_ff != '0, "division with zero steps left")
   `OTRNP_ASSERT_NEXT(a_last_step_packs, (seq_ff == SEQ_DIVIDE) && (step_ff == SW'(1)), seq_ff == SEQ_PACK, "division end did not reach pack")
   `OTRNP_ASSERT_NOW(a_no_emit_when_busy, seq_ff != SEQ_IDLE, !cmd.emit && !cmd.take_digit, "field command while division busy")

endmodule

`default_nettype wire

// ===== rtl/core/obj_text_record_number_parser.sv =====
// Top level of the OBJ text record number parser: controller plus datapath.
// Depends on otrnp_pkg, otrnp_ctrl and otrnp_datapath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_text_byte
//   rsp       out        rsp_valid / rsp_stall  kind, field number, fixed, index,
//                                               overflow, last_of_record
//
// Bytes that do not end a field are taken one per cycle while the sequencer is idle.
// A byte that ends a field with a result holds req_stall while the bit-serial divider
// runs and the result is loaded, and longer while a previous result sits unread in the
// output register.
// Synchronous reset puts the parser at line start; no clearing pass.
// rsp_stall only delays the load of the output register, never loses an item.
`timescale 1ns / 1ps
`default_nettype none

module obj_text_record_number_parser #(
   parameter int MANTISSA_BITS   = 32,
   parameter int MAX_FRAC_DIGITS = 9,
   parameter int FRAC_BITS       = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [7:0]         req_text_byte,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_record_kind,
   output logic [3:0]         rsp_field_number,
   output logic signed [31:0] rsp_fixed_value,
   output logic signed [31:0] rsp_index_value,
   output logic               rsp_overflow,
   output logic               rsp_last_of_record
);
   import otrnp_pkg::*;

   otrnp_cmd_type    cmd;
   otrnp_status_type status;

   // Line parser and division sequencer
   otrnp_ctrl #(
      .DIV_STEPS (MANTISSA_BITS + FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Field accumulator, divider and result register
   otrnp_datapath #(
      .MANTISSA_BITS   (MANTISSA_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .text_byte          (req_text_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_field_number   (rsp_field_number),
      .rsp_fixed_value    (rsp_fixed_value),
      .rsp_index_value    (rsp_index_value),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_of_record (rsp_last_of_record)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the OBJ text record number parser: streams OBJ text
// bytes, predicts each parsed field in-line and checks every result item.
// Depends on otrnp_pkg and obj_text_record_number_parser.
`timescale 1ns / 1ps

module testbench;
   import otrnp_pkg::*;

   localparam int MANTISSA_BITS   = 32;
   localparam int MAX_FRAC_DIGITS = 9;
   localparam int FRAC_BITS       = 16;
   localparam int ITEM_TARGET     = 1350;
   localparam int HOLD_CYCLES     = 800;
   localparam int DRAIN_CYCLES    = 120;
   localparam int LIMIT_NS        = 15_000_000;
   localparam logic [7:0]  CH_SLASH = 8'h2F;
   localparam logic [7:0]  CH_TAB   = 8'h09;
   localparam logic [63:0] MANT_MAX = (64'd1 << MANTISSA_BITS) - 64'd1;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  field;
      logic [31:0] fixed;
      logic [31:0] index;
      logic        ovf;
      logic        last;
   } field_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_text_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_record_kind;
   logic [3:0]        rsp_field_number;
   logic signed [31:0] rsp_fixed_value;
   logic signed [31:0] rsp_index_value;
   logic              rsp_overflow;
   logic              rsp_last_of_record;

   logic [7:0]        text_bytes[$];
   field_result_type  pending_fields[$];

   // parser shadow state
   line_phase_type    phase;
   logic [1:0]        rec_kind;
   int                field_idx;
   logic [63:0]       mantissa;
   int                frac_digits;
   bit                negative, point_seen, at_field_start, mant_saturated;

   bit                byte_taken;
   bit                long_hold = 1'b0;
   bit                quiet;
   int                send_gap, stall_left;
   int                cycle_count, accepted_bytes, error_count;
   int                fields_checked, ovf_seen, last_seen;
   int                kind_count[4];

   obj_text_record_number_parser #(
      .MANTISSA_BITS  (MANTISSA_BITS),
      .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
      .FRAC_BITS      (FRAC_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_field_number  (rsp_field_number),
      .rsp_fixed_value   (rsp_fixed_value),
      .rsp_index_value   (rsp_index_value),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_record(rsp_last_of_record)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int fields_in_record(input logic [1:0] kind);
      case (kind)
         KIND_TEXTURE: return 2;
         KIND_FACE:    return 9;
         default:      return 3;
      endcase
   endfunction

   task automatic clear_number();
      mantissa       = 64'd0;
      frac_digits    = 0;
      negative       = 1'b0;
      point_seen     = 1'b0;
      at_field_start = 1'b1;
      mant_saturated = 1'b0;
   endtask

   // decimal accumulate, pinned at the mantissa maximum
   task automatic shift_in_digit(input logic [7:0] b);
      logic [63:0] d;
      d = 64'(b - CH_ZERO);
      if (mantissa > (MANT_MAX - d) / 64'd10) begin
         mantissa       = MANT_MAX;
         mant_saturated = 1'b1;
      end else begin
         mantissa = mantissa * 64'd10 + d;
      end
   endtask

   // advance the line parser by one byte; queue the field it ends, if any
   task automatic parse_byte(input logic [7:0] b);
      logic             eol;
      logic [63:0]      scale, quot, rem, lim, mag;
      field_result_type res;
      eol = (b == CH_NEWLINE) || (b == CH_NUL);
      case (phase)
         PH_START: begin
            if (!eol) begin
               if (b == CH_F) begin
                  rec_kind = KIND_FACE;
                  phase    = PH_HEADER;
               end else if (b == CH_V) begin
                  phase = PH_AFTER_V;
               end else begin
                  phase = PH_SKIP;
               end
            end
         end
         PH_AFTER_V: begin
            if (eol) begin
               phase = PH_START;
            end else if (b == CH_SPACE) begin
               rec_kind  = KIND_VERTEX;
               field_idx = 0;
               clear_number();
               phase     = PH_FIELDS;
            end else if (b == CH_T) begin
               rec_kind = KIND_TEXTURE;
               phase    = PH_HEADER;
            end else if (b == CH_N) begin
               rec_kind = KIND_NORMAL;
               phase    = PH_HEADER;
            end else begin
               phase = PH_SKIP;
            end
         end
         PH_HEADER: begin
            if (eol) begin
               phase = PH_START;
            end else begin
               field_idx = 0;
               clear_number();
               phase     = PH_FIELDS;
            end
         end
         PH_FIELDS: begin
            if (at_field_start && b == CH_MINUS) begin
               negative       = 1'b1;
               at_field_start = 1'b0;
            end else if (b == CH_POINT) begin
               point_seen     = 1'b1;
               at_field_start = 1'b0;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
               at_field_start = 1'b0;
               if (!point_seen) begin
                  shift_in_digit(b);
               end else if (frac_digits < MAX_FRAC_DIGITS) begin
                  shift_in_digit(b);
                  frac_digits++;
               end
            end else begin
               // field ends; an empty field cut by end of line is dropped
               if (!at_field_start || !eol) begin
                  scale = 64'd1;
                  repeat (frac_digits) scale = scale * 64'd10;
                  quot      = mantissa / scale;
                  rem       = mantissa % scale;
                  res.kind  = rec_kind;
                  res.field = 4'(field_idx);
                  res.fixed = 32'd0;
                  res.index = 32'd0;
                  res.ovf   = mant_saturated;
                  res.last  = (field_idx + 1 == fields_in_record(rec_kind));
                  if (rec_kind == KIND_FACE) begin
                     // zero-based index: integer part minus one
                     if (negative) begin
                        if (quot > 64'h7FFF_FFFF) begin
                           res.index = 32'h8000_0000;
                           res.ovf   = 1'b1;
                        end else begin
                           res.index = 32'(-quot - 64'd1);
                        end
                     end else begin
                        if (quot > 64'h8000_0000) begin
                           res.index = 32'h7FFF_FFFF;
                           res.ovf   = 1'b1;
                        end else begin
                           res.index = 32'(quot - 64'd1);
                        end
                     end
                  end else begin
                     // fixed point magnitude, saturated by sign
                     lim = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
                     if (quot > (lim >> FRAC_BITS)) begin
                        mag     = lim;
                        res.ovf = 1'b1;
                     end else begin
                        mag = (quot << FRAC_BITS) + ((rem << FRAC_BITS) / scale);
                        if (mag > lim) begin
                           mag     = lim;
                           res.ovf = 1'b1;
                        end
                     end
                     res.fixed = 32'(negative ? -mag : mag);
                  end
                  pending_fields.push_back(res);
               end
               field_idx++;
               if (eol) phase = PH_START;
               else if (field_idx >= fields_in_record(rec_kind)) phase = PH_SKIP;
               else clear_number();
            end
         end
         default: phase = eol ? PH_START : PH_SKIP;
      endcase
   endtask

   // idle lengths: mostly none or short, a few long, none in quiet stretches
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // ---------------- text generation ----------------
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   task automatic push_digits(input int n);
      repeat (n) text_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   function automatic logic [7:0] any_text_byte();
      logic [7:0] b;
      b = CH_NEWLINE;
      while (b == CH_NEWLINE) b = 8'($urandom_range(1, 255));
      return b;
   endfunction

   function automatic logic [7:0] pick_separator();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 55) return CH_SPACE;
      if (pick < 70) return CH_SLASH;
      if (pick < 78) return CH_TAB;
      if (pick < 84) return CH_MINUS;
      b = CH_POINT;
      while (b == CH_NEWLINE || b == CH_POINT || (b >= CH_ZERO && b <= CH_NINE))
         b = 8'($urandom_range(1, 255));
      return b;
   endfunction

   // values right at the saturation and rounding boundaries
   function automatic string boundary_number(input logic [1:0] kind);
      int pick;
      pick = $urandom_range(0, 5);
      if (kind == KIND_FACE) begin
         case (pick)
            0:       return "2147483648";
            1:       return "2147483649";
            2:       return "-2147483647";
            3:       return "-2147483648";
            4:       return "99999999999";
            default: return "0.9";
         endcase
      end
      case (pick)
         0:       return "32767.99999";
         1:       return "32768";
         2:       return "-32768";
         3:       return "-32768.00002";
         4:       return "-0";
         default: return "0.0000152587890625";
      endcase
   endfunction

   task automatic push_number(input logic [1:0] kind);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         push_text(boundary_number(kind));
      end else begin
         if ($urandom_range(0, 3) == 0) text_bytes.push_back(CH_MINUS);
         push_digits((pick < 16) ? $urandom_range(5, 12) : $urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) begin
            text_bytes.push_back(CH_POINT);
            push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(8, 13)
                                                    : $urandom_range(0, 4));
            // a second point is accepted and changes nothing
            if ($urandom_range(0, 15) == 0) begin
               text_bytes.push_back(CH_POINT);
               push_digits($urandom_range(0, 2));
            end
         end
      end
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (text_bytes.size() > 0) begin
            req_text_byte <= text_bytes.pop_front();
            req_valid     <= 1'b1;
            send_gap = gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls, forced high during the long hold-off
   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = gap_len();
      end
   end

   // ---------------- monitor: predict accepted bytes, check result items ----------------
   always @(posedge clock) begin
      field_result_type want;
      byte_taken = 1'b0;
      cycle_count++;
      quiet = (cycle_count % 5000) >= 4000;
      if (reset) begin
         phase     = PH_START;
         rec_kind  = KIND_VERTEX;
         field_idx = 0;
         clear_number();
         pending_fields.delete();
      end else begin
         if (req_valid && !req_stall) begin
            byte_taken = 1'b1;
            accepted_bytes++;
            parse_byte(req_text_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_fields.size() == 0) begin
               $error("result item with no field pending: kind %0d field %0d",
                      rsp_record_kind, rsp_field_number);
               error_count++;
            end else begin
               want = pending_fields.pop_front();
               fields_checked++;
               kind_count[want.kind]++;
               if (want.ovf) ovf_seen++;
               if (want.last) last_seen++;
               if (rsp_record_kind !== want.kind) begin
                  $error("record_kind: expected %0d, got %0d", want.kind, rsp_record_kind);
                  error_count++;
               end
               if (rsp_field_number !== want.field) begin
                  $error("field_number: expected %0d, got %0d", want.field, rsp_field_number);
                  error_count++;
               end
               if (rsp_fixed_value !== want.fixed) begin
                  $error("fixed_value: expected %0d, got %0d",
                         $signed(want.fixed), rsp_fixed_value);
                  error_count++;
               end
               if (rsp_index_value !== want.index) begin
                  $error("index_value: expected %0d, got %0d",
                         $signed(want.index), rsp_index_value);
                  error_count++;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow: expected %0d, got %0d", want.ovf, rsp_overflow);
                  error_count++;
               end
               if (rsp_last_of_record !== want.last) begin
                  $error("last_of_record: expected %0d, got %0d",
                         want.last, rsp_last_of_record);
                  error_count++;
               end
            end
         end
      end
   end

   // long receiver hold-off once traffic is flowing, so the parser backs up
   initial begin
      while (accepted_bytes < 400) @(posedge clock);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL obj_text_record_number_parser");
      $finish;
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      int         pick, nfields;
      logic [1:0] kind;

      // directed: signs, points, all-ones byte in a header,
      // zero byte ending a face early, newline inside a header
      push_text("v -1.5 2 .25\n");
      text_bytes.push_back(CH_F);
      text_bytes.push_back(8'hFF);
      push_text("0 -3");
      text_bytes.push_back(CH_NUL);
      push_text("vn\n");

      // random lines, mostly well-formed records with random numbers
      while (text_bytes.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            kind = 2'($urandom_range(0, 3));
            case (kind)
               KIND_VERTEX:  push_text("v ");
               KIND_TEXTURE: push_text("vt");
               KIND_NORMAL:  push_text("vn");
               default:      text_bytes.push_back(CH_F);
            endcase
            if (kind != KIND_VERTEX)
               text_bytes.push_back(($urandom_range(0, 4) == 0) ? any_text_byte() : CH_SPACE);
            nfields = fields_in_record(kind);
            pick = $urandom_range(0, 99);
            if (pick < 15) nfields = $urandom_range(0, nfields - 1);
            else if (pick < 25) nfields += $urandom_range(1, 2);
            for (int i = 0; i < nfields; i++) begin
               push_number(kind);
               if (i < nfields - 1 || $urandom_range(0, 2) == 0)
                  text_bytes.push_back(pick_separator());
            end
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  push_text("# ");
                  repeat ($urandom_range(0, 10)) text_bytes.push_back(any_text_byte());
               end
               1: repeat ($urandom_range(1, 12)) text_bytes.push_back(any_text_byte());
               2: begin
                  case ($urandom_range(0, 3))
                     0:       text_bytes.push_back(CH_V);
                     1:       push_text("vt");
                     2:       push_text("vn");
                     default: text_bytes.push_back(CH_F);
                  endcase
               end
               3: ;
               default: begin
                  text_bytes.push_back(CH_V);
                  text_bytes.push_back(any_text_byte());
                  push_text(" 1 2 3");
               end
            endcase
         end
         text_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_NEWLINE);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (text_bytes.size() != 0 || req_valid) @(posedge clock);
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d OBJ text bytes; checked %0d fields (vertex %0d, texture %0d,",
               accepted_bytes, fields_checked, kind_count[0], kind_count[1]);
      $display("normal %0d, face %0d), %0d saturated, %0d record ends, one long output hold.",
               kind_count[2], kind_count[3], ovf_seen, last_seen);
      if (error_count == 0) begin
         $display("PASS obj_text_record_number_parser");
      end else begin
         $display("FAIL obj_text_record_number_parser");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/otrnp_pkg.sv
rtl/core/otrnp_datapath.sv
rtl/core/otrnp_ctrl.sv
rtl/core/obj_text_record_number_parser.sv
tb/testbench.sv
